// File: hw/rtl/alu8_pkg.sv
// alu8_pkg: operation codes, flag layout and adjust constants for the 8-bit ALU.
// No dependencies; imported by alu8_core and cpu_8bit_alu_with_flags.
package alu8_pkg;

   typedef enum logic [4:0] {
      ACT_ADD  = 5'd0,
      ACT_ADC  = 5'd1,
      ACT_SUB  = 5'd2,
      ACT_SBC  = 5'd3,
      ACT_AND  = 5'd4,
      ACT_XOR  = 5'd5,
      ACT_OR   = 5'd6,
      ACT_CP   = 5'd7,
      ACT_RLCA = 5'd8,
      ACT_RRCA = 5'd9,
      ACT_RLA  = 5'd10,
      ACT_RRA  = 5'd11,
      ACT_DAA  = 5'd12,
      ACT_CPL  = 5'd13,
      ACT_SCF  = 5'd14,
      ACT_CCF  = 5'd15,
      ACT_INC  = 5'd16,
      ACT_DEC  = 5'd17
   } action_type;

   // bit3 Z, bit2 N, bit1 H, bit0 C
   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   localparam logic [7:0] DAA_HI_ADJ = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ = 8'h06;
   localparam logic [7:0] DAA_HI_MAX = 8'h99;
   localparam logic [3:0] DAA_LO_MAX = 4'h9;
   localparam logic [3:0] NIB_ONES   = 4'hF;

endpackage

// File: hw/rtl/alu8_core.sv
// alu8_core: combinational datapath, one operation from registered operands.
// Depends on alu8_pkg (action_type, flags_type, adjust constants).
module alu8_core (
   input  alu8_pkg::action_type action,
   input  logic [7:0]           acc,
   input  logic [7:0]           operand,
   input  alu8_pkg::flags_type  flags_in,
   output logic [7:0]           result,
   output alu8_pkg::flags_type  flags_out
);
   import alu8_pkg::*;

   logic       ci;
   logic [8:0] sum9;
   logic [4:0] hsum5;
   logic [8:0] diff9;
   logic [4:0] hdiff5;
   logic [7:0] daa_adj;
   logic       daa_c;
   logic [7:0] daa_r;
   logic [7:0] inc_r;
   logic [7:0] dec_r;

   // carry in only for adc / sbc
   assign ci = ((action == ACT_ADC) || (action == ACT_SBC)) ? flags_in.c : 1'b0;

   assign sum9   = {1'b0, acc} + {1'b0, operand} + {8'b0, ci};
   assign hsum5  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'b0, ci};
   assign diff9  = {1'b0, acc} - {1'b0, operand} - {8'b0, ci};
   assign hdiff5 = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'b0, ci};
   assign inc_r  = acc + 8'd1;
   assign dec_r  = acc - 8'd1;

   always_comb begin
      daa_adj = 8'd0;
      daa_c   = flags_in.c;
      if (!flags_in.n) begin
         if (flags_in.c || (acc > DAA_HI_MAX)) begin
            daa_adj = daa_adj | DAA_HI_ADJ;
            daa_c   = 1'b1;
         end
         if (flags_in.h || (acc[3:0] > DAA_LO_MAX)) begin
            daa_adj = daa_adj | DAA_LO_ADJ;
         end
         daa_r = acc + daa_adj;
      end else begin
         if (flags_in.c) begin
            daa_adj = daa_adj | DAA_HI_ADJ;
         end
         if (flags_in.h) begin
            daa_adj = daa_adj | DAA_LO_ADJ;
         end
         daa_r = acc - daa_adj;
      end
   end

   always_comb begin
      result    = acc;
      flags_out = flags_in;
      unique case (action)
         ACT_ADD, ACT_ADC: begin
            result    = sum9[7:0];
            flags_out = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            // C and H are borrows
            result    = (action == ACT_CP) ? acc : diff9[7:0];
            flags_out = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
         end
         ACT_AND: begin
            result    = acc & operand;
            flags_out = '{z: ((acc & operand) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         ACT_XOR: begin
            result    = acc ^ operand;
            flags_out = '{z: ((acc ^ operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_OR: begin
            result    = acc | operand;
            flags_out = '{z: ((acc | operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_RLCA: begin
            result    = {acc[6:0], acc[7]};
            flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
         end
         ACT_RRCA: begin
            result    = {acc[0], acc[7:1]};
            flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
         end
         ACT_RLA: begin
            result    = {acc[6:0], flags_in.c};
            flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
         end
         ACT_RRA: begin
            result    = {flags_in.c, acc[7:1]};
            flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
         end
         ACT_DAA: begin
            result    = daa_r;
            flags_out = '{z: (daa_r == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
         end
         ACT_CPL: begin
            result    = ~acc;
            flags_out = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
         end
         ACT_SCF: begin
            flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
         end
         ACT_CCF: begin
            flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~flags_in.c};
         end
         ACT_INC: begin
            result    = inc_r;
            flags_out = '{z: (inc_r == 8'd0), n: 1'b0, h: (acc[3:0] == NIB_ONES),
                          c: flags_in.c};
         end
         ACT_DEC: begin
            result    = dec_r;
            flags_out = '{z: (dec_r == 8'd0), n: 1'b1, h: (acc[3:0] == 4'd0),
                          c: flags_in.c};
         end
         default: begin
            // unused codes: pass acc and flags through
            result    = acc;
            flags_out = flags_in;
         end
      endcase
   end

endmodule

// File: hw/rtl/cpu_8bit_alu_with_flags.sv
// cpu_8bit_alu_with_flags: top level, operand register, datapath and result register.
// Depends on alu8_pkg and alu8_core.

// 8-bit accumulator ALU with Z/N/H/C flags. Every item carries an operation
// code, the accumulator, a second operand and the current flags, and yields
// exactly one item with the new 8-bit value and new flags. Items are taken
// in order and may arrive every cycle: throughput is one item per clock
// whenever rsp_stall is low. The accepting edge loads the operand register
// and a later edge, once the result register is free, loads the result
// register, which drives rsp_valid. The whole operation is evaluated by
// alu8_core between the two registers. When the result register is held by
// rsp_stall, one more item can wait in the operand register; req_stall goes
// high only while both are full and the result side is stalled. Unused
// operation codes (18..31) return acc and flags_in unchanged. No
// configuration, no internal state beyond the pipe.
module cpu_8bit_alu_with_flags (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [4:0] req_action,
   input  logic [7:0] req_acc,
   input  logic [7:0] req_operand,
   input  logic [3:0] req_flags_in,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_result,
   output logic [3:0] rsp_flags_out
);
   import alu8_pkg::*;

   // operand stage
   logic       s1_valid_ff, s1_valid_in;
   action_type s1_action_ff;
   logic [7:0] s1_acc_ff;
   logic [7:0] s1_operand_ff;
   flags_type  s1_flags_ff;

   // result stage
   logic       s2_valid_ff, s2_valid_in;
   logic [7:0] s2_result_ff;
   flags_type  s2_flags_ff;

   logic       s1_load;
   logic       s2_load;
   logic [7:0] core_result;
   flags_type  core_flags;

   // result register frees when empty or being taken this cycle
   assign s2_load   = !s2_valid_ff || !rsp_stall;
   // operand register frees when empty or moving forward
   assign req_stall = s1_valid_ff && !s2_load;
   assign s1_load   = req_valid && !req_stall;

   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_action_ff  <= action_type'(req_action);
         s1_acc_ff     <= req_acc;
         s1_operand_ff <= req_operand;
         s1_flags_ff   <= flags_type'(req_flags_in);
      end
   end

   alu8_core u_core (
      .action    (s1_action_ff),
      .acc       (s1_acc_ff),
      .operand   (s1_operand_ff),
      .flags_in  (s1_flags_ff),
      .result    (core_result),
      .flags_out (core_flags)
   );

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         s2_result_ff <= core_result;
         s2_flags_ff  <= core_flags;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_result    = s2_result_ff;
   assign rsp_flags_out = s2_flags_ff;

endmodule

// File: hw/rtl/alu8_checker.sv
// alu8_checker: port-level checks on the ALU pipe, bound to the top level.
// Depends on cpu_8bit_alu_with_flags ports only.
module alu8_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_result,
   input logic [3:0] rsp_flags_out
);

   // held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result) && $stable(rsp_flags_out))
      else $error("stalled result changed");

   // input backpressure only comes from a stalled full output
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without output backpressure");

   // an accepted item reaches rsp_valid when the output is free
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)
      else $error("item lost in pipe");

   // a fresh result always comes from an item that passed through the operand register without waiting
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without an item");

endmodule

bind cpu_8bit_alu_with_flags alu8_checker u_alu8_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_result    (rsp_result),
   .rsp_flags_out (rsp_flags_out)
);

// File: sim/tb.sv
// tb: self-checking bench for cpu_8bit_alu_with_flags (sm83-style ALU, Z/N/H/C).
// Depends on alu8_pkg and the RTL top; holds its own flag predictor and a
// valid/stall driver and monitor with random idling on both channels.
`timescale 1ns / 100ps

module tb;
   import alu8_pkg::*;

   // Codes 18..31 are unused: the block must pass acc and flags through.
   localparam logic [4:0] ACT_NOP_LO  = 5'd18;
   localparam logic [4:0] ACT_NOP_HI  = 5'd31;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         CALM_ITEMS  = 150;   // tail of the run with no idling
   localparam int         RAND_ITEMS  = 1350;

   typedef struct {
      logic [4:0] action;
      logic [7:0] acc;
      logic [7:0] operand;
      logic [3:0] flags;
      bit         drain_first;   // sender waits for all results before this item
   } alu_op_type;

   typedef struct {
      logic [4:0] action;
      logic [7:0] result;
      flags_type  flags;
   } alu_answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [4:0] req_action = '0;
   logic [7:0] req_acc = '0;
   logic [7:0] req_operand = '0;
   logic [3:0] req_flags_in = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_result;
   logic [3:0] rsp_flags_out;

   alu_op_type     op_q[$];       // items not yet offered to the block
   alu_answer_type answer_q[$];   // predicted results, oldest first
   int          answers_seen = 0;
   int          bad_count = 0;
   int          cycle_count = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          send_odds = 0;   // chance in ten of an idle burst, per window
   int          recv_odds = 0;
   logic        req_taken = 1'b0; // item accepted at the last rising edge
   logic        calm = 1'b0;      // end of run: no idling on either side

   cpu_8bit_alu_with_flags u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_acc       (req_acc),
      .req_operand   (req_operand),
      .req_flags_in  (req_flags_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result),
      .rsp_flags_out (rsp_flags_out)
   );

   always #4 clock = ~clock;

   // Predicts result and flags of one operation.
   // Add: carry out of bit 7, half carry out of bit 3.
   // Sub/sbc/cp: C and H are borrows, computed as bit 8 / bit 4 of a
   // zero-extended difference (wraps negative into the top bit).
   function automatic alu_answer_type alu_predict(logic [4:0] act, logic [7:0] a,
                                                  logic [7:0] b, flags_type fin);
      alu_answer_type ans;
      logic [8:0]  wide;
      logic [4:0]  nib;
      logic        ci;
      logic [7:0]  r;
      logic        c;
      ans.action = act;
      ans.result = a;
      ans.flags  = fin;
      ci = 1'b0;
      case (act)
         ACT_ADD, ACT_ADC: begin
            ci   = (act == ACT_ADC) ? fin.c : 1'b0;
            wide = {1'b0, a} + {1'b0, b} + {8'd0, ci};
            nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
            ans.result = wide[7:0];
            ans.flags  = '{z: wide[7:0] == 8'd0, n: 1'b0, h: nib[4], c: wide[8]};
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            ci   = (act == ACT_SBC) ? fin.c : 1'b0;
            wide = {1'b0, a} - {1'b0, b} - {8'd0, ci};
            nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
            ans.result = (act == ACT_CP) ? a : wide[7:0];
            ans.flags  = '{z: wide[7:0] == 8'd0, n: 1'b1, h: nib[4], c: wide[8]};
         end
         ACT_AND: begin
            ans.result = a & b;
            ans.flags  = '{z: (a & b) == 8'd0, n: 1'b0, h: 1'b1, c: 1'b0};
         end
         ACT_XOR: begin
            ans.result = a ^ b;
            ans.flags  = '{z: (a ^ b) == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
         end
         ACT_OR: begin
            ans.result = a | b;
            ans.flags  = '{z: (a | b) == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
         end
         // rotates always clear Z
         ACT_RLCA: begin
            ans.result = {a[6:0], a[7]};
            ans.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
         end
         ACT_RRCA: begin
            ans.result = {a[0], a[7:1]};
            ans.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
         end
         ACT_RLA: begin
            ans.result = {a[6:0], fin.c};
            ans.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
         end
         ACT_RRA: begin
            ans.result = {fin.c, a[7:1]};
            ans.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
         end
         ACT_DAA: begin
            r = a;
            c = fin.c;
            if (!fin.n) begin
               if (fin.c || a > DAA_HI_MAX) begin
                  r = r + DAA_HI_ADJ;
                  c = 1'b1;
               end
               if (fin.h || a[3:0] > DAA_LO_MAX)
                  r = r + DAA_LO_ADJ;
            end else begin
               // after a subtraction the carry is only kept
               if (fin.c)
                  r = r - DAA_HI_ADJ;
               if (fin.h)
                  r = r - DAA_LO_ADJ;
            end
            ans.result = r;
            ans.flags  = '{z: r == 8'd0, n: fin.n, h: 1'b0, c: c};
         end
         ACT_CPL: begin
            ans.result = ~a;
            ans.flags  = '{z: fin.z, n: 1'b1, h: 1'b1, c: fin.c};
         end
         ACT_SCF:
            ans.flags = '{z: fin.z, n: 1'b0, h: 1'b0, c: 1'b1};
         ACT_CCF:
            ans.flags = '{z: fin.z, n: 1'b0, h: 1'b0, c: ~fin.c};
         // inc/dec leave C alone
         ACT_INC: begin
            ans.result = a + 8'd1;
            ans.flags  = '{z: a == 8'hFF, n: 1'b0, h: a[3:0] == NIB_ONES, c: fin.c};
         end
         ACT_DEC: begin
            ans.result = a - 8'd1;
            ans.flags  = '{z: a == 8'h01, n: 1'b1, h: a[3:0] == 4'h0, c: fin.c};
         end
         default: ;   // unused code: pass through
      endcase
      return ans;
   endfunction

   // Byte source weighted toward the values where carries and DAA bounds sit.
   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[8];
      corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h99, 8'h9A, 8'h80, 8'h01};
      if ($urandom_range(0, 7) == 0)
         return corners[$urandom_range(0, 7)];
      return 8'($urandom);
   endfunction

   task automatic add_op(logic [4:0] act, logic [7:0] a, logic [7:0] b,
                         logic [3:0] f, bit drain);
      alu_op_type op;
      op.action      = act;
      op.acc         = a;
      op.operand     = b;
      op.flags       = f;
      op.drain_first = drain;
      op_q.push_back(op);
   endtask

   // Cycle counter, idling odds redrawn whenever the low byte of the count is zero, and the watchdog.
   // A window with odds 0 gives a stretch with no idling at all.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm        <= op_q.size() < CALM_ITEMS;
      if (cycle_count[7:0] == 8'd0) begin
         send_odds <= $urandom_range(0, 3);
         recv_odds <= $urandom_range(0, 3);
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Request driver, updates on the falling edge. The payload holds until the
   // item is taken; after each taken item an idle burst may start. An item
   // marked drain_first is held back until every predicted result has come.
   always @(negedge clock) begin : driver
      alu_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken && !calm && $urandom_range(0, 9) < send_odds)
            gap_left = $urandom_range(1, 16);
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (op_q.size() != 0 &&
                      (!op_q[0].drain_first || answer_q.size() == 0)) begin
            op = op_q.pop_front();
            req_action   <= op.action;
            req_acc      <= op.acc;
            req_operand  <= op.operand;
            req_flags_in <= op.flags;
            req_valid    <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure: random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) < recv_odds) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor on the rising edge: check the result item first, then predict
   // the request item taken at this same edge (latency keeps them apart).
   always @(posedge clock) begin : monitor
      alu_answer_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               bad_count = bad_count + 1;
               if (bad_count <= 10)
                  $display("%0d: result item with none pending: result %h flags %b",
                           cycle_count, rsp_result, rsp_flags_out);
            end else begin
               want = answer_q.pop_front();
               answers_seen <= answers_seen + 1;
               if (rsp_result !== want.result || rsp_flags_out !== want.flags) begin
                  bad_count = bad_count + 1;
                  if (bad_count <= 10)
                     $display("%0d: action %0d result %h flags %b, expected %h %b",
                              cycle_count, want.action, rsp_result, rsp_flags_out,
                              want.result, want.flags);
               end
            end
         end
         if (req_valid && !req_stall)
            answer_q.push_back(alu_predict(req_action, req_acc, req_operand,
                                           flags_type'(req_flags_in)));
         req_taken <= req_valid && !req_stall;
      end
   end

   initial begin : run
      int total;
      int pick;
      logic [4:0] act;

      // Directed items. Flags are {Z,N,H,C}.
      add_op(ACT_ADD,  8'hFF, 8'h01, 4'b0000, 1'b0); // zero, half and full carry
      add_op(ACT_ADC,  8'h0F, 8'h00, 4'b0001, 1'b0); // carry-in makes half carry
      add_op(ACT_ADC,  8'hFF, 8'hFF, 4'b0001, 1'b0); // largest sum
      add_op(ACT_SUB,  8'h00, 8'h01, 4'b0000, 1'b0); // borrow out of both nibbles
      add_op(ACT_SBC,  8'h10, 8'h0F, 4'b0001, 1'b0); // borrow-in gives zero
      add_op(ACT_AND,  8'hFF, 8'h00, 4'b0000, 1'b0); // zero, H always set
      add_op(ACT_XOR,  8'hAA, 8'h55, 4'b1111, 1'b0);
      add_op(ACT_OR,   8'h00, 8'h00, 4'b1111, 1'b0);
      add_op(ACT_CP,   8'h3C, 8'h3C, 4'b0000, 1'b0); // equal: Z, acc unchanged
      add_op(ACT_CP,   8'h00, 8'hFF, 4'b0000, 1'b0);
      add_op(ACT_RLCA, 8'h80, 8'h00, 4'b1111, 1'b0); // Z cleared though result 01
      add_op(ACT_RRCA, 8'h01, 8'h00, 4'b0000, 1'b0);
      add_op(ACT_RLA,  8'h80, 8'h00, 4'b0001, 1'b0); // old carry shifted in
      add_op(ACT_RRA,  8'h01, 8'h00, 4'b0000, 1'b0); // zero result, Z still clear
      add_op(ACT_DAA,  8'h9A, 8'h00, 4'b0000, 1'b0); // above 99 and low nibble > 9
      add_op(ACT_DAA,  8'h00, 8'h00, 4'b0011, 1'b0); // H and C after an add
      add_op(ACT_DAA,  8'h00, 8'h00, 4'b0111, 1'b0); // after a subtraction
      add_op(ACT_CPL,  8'h5A, 8'h00, 4'b1001, 1'b0);
      add_op(ACT_SCF,  8'h12, 8'h00, 4'b1010, 1'b0);
      add_op(ACT_CCF,  8'h12, 8'h00, 4'b1001, 1'b0);
      add_op(ACT_INC,  8'hFF, 8'h00, 4'b0001, 1'b0); // wraps to zero, C kept
      add_op(ACT_DEC,  8'h00, 8'h00, 4'b0000, 1'b0); // borrow into bit 4
      add_op(ACT_DEC,  8'h01, 8'h00, 4'b0001, 1'b0); // reaches zero
      add_op(ACT_NOP_LO, 8'hC3, 8'h3C, 4'b1010, 1'b0);
      add_op(ACT_NOP_HI, 8'h5A, 8'hA5, 4'b0101, 1'b0);

      // Random items; now and then a code from the unused range. The sender
      // drains the pipe before the first random item and once mid-run.
      for (int i = 0; i < RAND_ITEMS; i++) begin
         pick = $urandom_range(0, 19);
         if (pick >= 18)
            act = 5'($urandom_range(ACT_NOP_LO, ACT_NOP_HI));
         else
            act = 5'(pick);
         add_op(act, pick_byte(), pick_byte(), 4'($urandom),
                i == 0 || i == RAND_ITEMS / 2);
      end
      total = op_q.size();

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (answers_seen != total)
         @(posedge clock);
      // let any stray result item show up
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (bad_count == 0 && answer_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
